// ----- sv/olsr_dff_pkg.sv -----
// ----------------------------------------------------------------------------
// OLSR duplicate filter package
// Shared constants, command and status codes, and the transaction types of the
// duplicate filter and forwarder.
// ----------------------------------------------------------------------------
package olsr_dff_pkg;

  localparam int unsigned DUP_DEPTH = 16;
  localparam int unsigned SEL_DEPTH = 16;
  localparam logic [15:0] HOLD_DEFAULT = 16'd30000;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS = '0;

  typedef enum logic [1:0] {
    CMD_MESSAGE    = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_SEL_ADD    = 2'd2,
    CMD_SEL_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_FORWARDED    = 3'd0,
    ST_DUPLICATE    = 3'd1,
    ST_NOT_SELECTOR = 3'd2,
    ST_TTL_EXPIRED  = 3'd3,
    ST_DONE         = 3'd4,
    ST_SEL_FULL     = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] originator;
    logic [15:0] sequence_req;
    logic [31:0] sender;
    logic [7:0]  time_to_live;
    logic [7:0]  hop_count;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        forward;
    logic [7:0]  new_ttl;
    logic [7:0]  new_hop_count;
    logic        dup_full;
  } rsp_t;

  typedef struct packed {
    logic hit;
    logic sent;
    logic full;
  } dup_look_t;

  typedef struct packed {
    logic hit;
    logic full;
  } sel_look_t;

endpackage

// ----- sv/olsr_duplicate_filter_forwarder.sv -----
// ----------------------------------------------------------------------------
// OLSR duplicate filter and forwarder
// Default forwarding decision for OLSR message headers, with a duplicate set,
// an MPR selector set and tick-driven expiry of duplicate entries.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  req       in         req_valid_i / req_ready_o  req_i (olsr_dff_pkg::req_t)
//  rsp       out        rsp_valid_o / rsp_ready_i  rsp_o (olsr_dff_pkg::rsp_t)
//  apb       in/out     psel, penable, pready      paddr, pwdata, prdata
//
// One transaction per cycle is accepted and answered while rsp is not stalled;
// each passes through the input register and then the result register to rsp.
// Both set searches and all state updates happen in the cycle an item moves
// from the input register to the result register.
// Reset clears both sets at once and restores the default hold time.
// A stalled rsp holds the result register, and req_ready_o drops only when
// both registers are occupied.
// ----------------------------------------------------------------------------
module olsr_duplicate_filter_forwarder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  olsr_dff_pkg::req_t              req_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output olsr_dff_pkg::rsp_t              rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [olsr_dff_pkg::APB_AW-1:0] paddr,
  input  logic [olsr_dff_pkg::APB_DW-1:0] pwdata,
  output logic [olsr_dff_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import olsr_dff_pkg::*;

  req_t        req_q;
  logic        req_vld_q;
  rsp_t        rsp_q, rsp_d;
  logic        rsp_vld_q;
  logic        move;
  logic [15:0] hold_ticks;
  dup_look_t   dup_look;
  sel_look_t   sel_look;
  logic [7:0]  nttl, nhop;
  logic        fwd;

  assign move        = req_vld_q && (!rsp_vld_q || rsp_ready_i);
  assign req_ready_o = !req_vld_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_ready_o) begin
        req_vld_q <= req_valid_i;
      end
      if (move) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      req_q <= req_i;
    end
    if (move) begin
      rsp_q <= rsp_d;
    end
  end

  olsr_dff_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .hold_ticks_o (hold_ticks)
  );

  olsr_dff_dup_set u_dup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (move),
    .req_i        (req_q),
    .hold_ticks_i (hold_ticks),
    .mark_i       (fwd),
    .look_o       (dup_look)
  );

  olsr_dff_sel_set u_sel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (move),
    .req_i  (req_q),
    .look_o (sel_look)
  );

  assign nttl = req_q.time_to_live - 8'd1;
  assign nhop = req_q.hop_count + 8'd1;
  assign fwd  = (req_q.cmd == CMD_MESSAGE) && !(dup_look.hit && dup_look.sent) &&
                sel_look.hit && (nttl != 8'd0);

  always_comb begin
    rsp_d = '{status: ST_DONE, forward: 1'b0, new_ttl: 8'd0, new_hop_count: 8'd0,
              dup_full: 1'b0};
    case (req_q.cmd)
      CMD_MESSAGE: begin
        if (dup_look.hit && dup_look.sent) begin
          rsp_d.status = ST_DUPLICATE;
        end else begin
          rsp_d.dup_full = dup_look.full;
          if (!sel_look.hit) begin
            rsp_d.status = ST_NOT_SELECTOR;
          end else begin
            rsp_d.new_ttl       = nttl;
            rsp_d.new_hop_count = nhop;
            rsp_d.status        = fwd ? ST_FORWARDED : ST_TTL_EXPIRED;
            rsp_d.forward       = fwd;
          end
        end
      end
      CMD_SEL_ADD: begin
        rsp_d.status = sel_look.full ? ST_SEL_FULL : ST_DONE;
      end
      default: begin
        rsp_d.status = ST_DONE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- sv/olsr_dff_apb_regs.sv -----
// ----------------------------------------------------------------------------
// OLSR duplicate filter configuration registers
// APB-style register file holding the hold time of duplicate entries.
// ----------------------------------------------------------------------------
module olsr_dff_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [olsr_dff_pkg::APB_AW-1:0]   paddr,
  input  logic [olsr_dff_pkg::APB_DW-1:0]   pwdata,
  output logic [olsr_dff_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output logic [15:0]                       hold_ticks_o
);
  import olsr_dff_pkg::*;

  logic [15:0] hold_ticks_q;
  logic        hold_sel;

  assign hold_sel = (paddr[APB_AW-1:2] == REG_HOLD_TICKS);
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_DEFAULT;
    end else if (psel && penable && pwrite && pready && hold_sel) begin
      hold_ticks_q <= pwdata[15:0];
    end
  end

  assign prdata       = hold_sel ? {{(APB_DW-16){1'b0}}, hold_ticks_q} : '0;
  assign hold_ticks_o = hold_ticks_q;

endmodule

// ----- sv/olsr_dff_dup_set.sv -----
// ----------------------------------------------------------------------------
// OLSR duplicate set
// Duplicate tuples with hold timers, searched by parallel compare, filled in
// the lowest free slot and aged by tick transactions.
// ----------------------------------------------------------------------------
module olsr_dff_dup_set (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  olsr_dff_pkg::req_t      req_i,
  input  logic [15:0]             hold_ticks_i,
  input  logic                    mark_i,
  output olsr_dff_pkg::dup_look_t look_o
);
  import olsr_dff_pkg::*;

  logic [DUP_DEPTH-1:0] valid_q, valid_d;
  logic [DUP_DEPTH-1:0] sent_q, sent_d;
  logic [DUP_DEPTH-1:0] match, free_oh, slot_oh;
  logic [15:0]          remain_q [DUP_DEPTH];
  logic [15:0]          remain_d [DUP_DEPTH];
  logic [31:0]          origin_q [DUP_DEPTH];
  logic [15:0]          seq_q    [DUP_DEPTH];
  logic                 is_msg, is_tick, ins;

  assign is_msg  = (req_i.cmd == CMD_MESSAGE);
  assign is_tick = (req_i.cmd == CMD_TICK);

  always_comb begin
    for (int i = 0; i < DUP_DEPTH; i++) begin
      match[i] = valid_q[i] && (origin_q[i] == req_i.originator) &&
                 (seq_q[i] == req_i.sequence_req);
    end
  end

  assign free_oh     = ~valid_q & (valid_q + DUP_DEPTH'(1));
  assign look_o.hit  = |match;
  assign look_o.sent = |(match & sent_q);
  assign look_o.full = !look_o.hit && (&valid_q);
  assign ins         = fire_i && is_msg && !look_o.hit && !(&valid_q);
  assign slot_oh     = look_o.hit ? match : free_oh;

  always_comb begin
    valid_d  = valid_q;
    sent_d   = sent_q;
    remain_d = remain_q;
    if (ins) begin
      valid_d = valid_q | free_oh;
      sent_d  = sent_q & ~free_oh;
      for (int i = 0; i < DUP_DEPTH; i++) begin
        if (free_oh[i]) begin
          remain_d[i] = hold_ticks_i;
        end
      end
    end
    if (fire_i && is_msg && mark_i) begin
      sent_d = sent_d | slot_oh;
    end
    if (fire_i && is_tick) begin
      for (int i = 0; i < DUP_DEPTH; i++) begin
        if (valid_q[i]) begin
          if (remain_q[i] <= 16'd1) begin
            valid_d[i]  = 1'b0;
            sent_d[i]   = 1'b0;
            remain_d[i] = '0;
          end else begin
            remain_d[i] = remain_q[i] - 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      sent_q  <= '0;
      for (int i = 0; i < DUP_DEPTH; i++) begin
        remain_q[i] <= '0;
      end
    end else begin
      valid_q  <= valid_d;
      sent_q   <= sent_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DUP_DEPTH; i++) begin
      if (ins && free_oh[i]) begin
        origin_q[i] <= req_i.originator;
        seq_q[i]    <= req_i.sequence_req;
      end
    end
  end

endmodule

// ----- sv/olsr_dff_sel_set.sv -----
// ----------------------------------------------------------------------------
// OLSR MPR selector set
// Selector addresses searched by parallel compare, added in the lowest free
// slot and removed on every matching entry.
// ----------------------------------------------------------------------------
module olsr_dff_sel_set (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  olsr_dff_pkg::req_t      req_i,
  output olsr_dff_pkg::sel_look_t look_o
);
  import olsr_dff_pkg::*;

  logic [SEL_DEPTH-1:0] valid_q, valid_d;
  logic [SEL_DEPTH-1:0] match, free_oh;
  logic [31:0]          addr_q [SEL_DEPTH];
  logic                 ins;

  always_comb begin
    for (int i = 0; i < SEL_DEPTH; i++) begin
      match[i] = valid_q[i] && (addr_q[i] == req_i.sender);
    end
  end

  assign free_oh     = ~valid_q & (valid_q + SEL_DEPTH'(1));
  assign look_o.hit  = |match;
  assign look_o.full = !look_o.hit && (&valid_q);
  assign ins = fire_i && (req_i.cmd == CMD_SEL_ADD) && !look_o.hit && !(&valid_q);

  always_comb begin
    valid_d = valid_q;
    if (ins) begin
      valid_d = valid_q | free_oh;
    end
    if (fire_i && (req_i.cmd == CMD_SEL_REMOVE)) begin
      valid_d = valid_q & ~match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SEL_DEPTH; i++) begin
      if (ins && free_oh[i]) begin
        addr_q[i] <= req_i.sender;
      end
    end
  end

endmodule

// ----- sv/olsr_dff_checker.sv -----
// ----------------------------------------------------------------------------
// OLSR duplicate filter port checker
// Concurrent checks on the ports of the duplicate filter and forwarder.
// ----------------------------------------------------------------------------
module olsr_dff_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_o,
  input logic               rsp_ready_i,
  input olsr_dff_pkg::rsp_t rsp_o,
  input logic               pready
);
  import olsr_dff_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.forward == (rsp_o.status == ST_FORWARDED)))
    else $error("forward flag disagrees with status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == ST_DUPLICATE) |->
      !rsp_o.dup_full && (rsp_o.new_ttl == 8'd0) && (rsp_o.new_hop_count == 8'd0))
    else $error("duplicate result carries header fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == ST_TTL_EXPIRED) |-> (rsp_o.new_ttl == 8'd0))
    else $error("ttl expired with nonzero ttl");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready deasserted");

endmodule

bind olsr_duplicate_filter_forwarder olsr_dff_checker u_checker (.*);

// ----- tb/tb_olsr_duplicate_filter_forwarder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLSR duplicate filter and forwarder testbench
// Drives message headers, ticks and selector commands through the request
// channel and predicts every response with a cycle-free model of the duplicate
// set, the MPR selector set and the hold-time register. Directed tests cover
// wrap-around, duplicates, full sets and the hold-time extremes; random phases
// with varying hold times and handshake idling follow. A receiver hold-off
// fills the pipeline to exercise input backpressure.
// ----------------------------------------------------------------------------
module tb_olsr_duplicate_filter_forwarder;
  import olsr_dff_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLDOFF = 400;
  localparam logic [APB_AW-1:0] ADDR_HOLD = {REG_HOLD_TICKS, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE = ADDR_HOLD + 3'd4;
  localparam logic [31:0] SEL_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] SEL_ZERO = 32'h0000_0000;
  localparam logic [31:0] NON_SELECTOR = 32'h0BAD_0000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              req_valid;
  logic              req_ready;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_t              rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  always #1 clk = ~clk;

  olsr_duplicate_filter_forwarder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  bit          dup_live [DUP_DEPTH];
  logic [31:0] dup_orig [DUP_DEPTH];
  logic [15:0] dup_sn   [DUP_DEPTH];
  bit          dup_fwd  [DUP_DEPTH];
  logic [15:0] dup_left [DUP_DEPTH];
  bit          sel_live [SEL_DEPTH];
  logic [31:0] sel_addr [SEL_DEPTH];
  logic [15:0] hold_cfg;

  rsp_t        pending_rsp [$];
  int          mismatches = 0;
  int          rsp_count = 0;
  int          send_gap_max = 0;
  int          recv_gap_max = 0;
  int          rsp_holdoff = 0;

  logic [31:0] sel_pool  [8];
  logic [31:0] orig_pool [4];
  logic [15:0] seq_base;

  function automatic rsp_t forward_decision(input req_t r);
    rsp_t o;
    int   i;
    int   hit;
    int   slot;
    bit   is_sel;
    o = '0;
    o.status = ST_DONE;
    case (r.cmd)
      CMD_MESSAGE: begin
        hit = -1;
        for (i = 0; i < DUP_DEPTH; i++)
          if (hit < 0 && dup_live[i] && dup_orig[i] == r.originator &&
              dup_sn[i] == r.sequence_req)
            hit = i;
        if (hit >= 0 && dup_fwd[hit]) begin
          o.status = ST_DUPLICATE;
          return o;
        end
        slot = hit;
        if (hit < 0) begin
          for (i = 0; i < DUP_DEPTH; i++)
            if (slot < 0 && !dup_live[i]) slot = i;
          if (slot >= 0) begin
            dup_live[slot] = 1'b1;
            dup_orig[slot] = r.originator;
            dup_sn[slot]   = r.sequence_req;
            dup_fwd[slot]  = 1'b0;
            dup_left[slot] = hold_cfg;
          end else begin
            o.dup_full = 1'b1;
          end
        end
        is_sel = 1'b0;
        for (i = 0; i < SEL_DEPTH; i++)
          if (sel_live[i] && sel_addr[i] == r.sender) is_sel = 1'b1;
        if (!is_sel) begin
          o.status = ST_NOT_SELECTOR;
        end else begin
          o.new_ttl = r.time_to_live - 8'd1;
          o.new_hop_count = r.hop_count + 8'd1;
          if (o.new_ttl == 8'd0) begin
            o.status = ST_TTL_EXPIRED;
          end else begin
            o.status = ST_FORWARDED;
            o.forward = 1'b1;
            if (slot >= 0) dup_fwd[slot] = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        for (i = 0; i < DUP_DEPTH; i++) begin
          if (dup_live[i]) begin
            if (dup_left[i] <= 16'd1) begin
              dup_live[i] = 1'b0;
              dup_fwd[i]  = 1'b0;
              dup_left[i] = '0;
            end else begin
              dup_left[i] = dup_left[i] - 16'd1;
            end
          end
        end
      end
      CMD_SEL_ADD: begin
        is_sel = 1'b0;
        for (i = 0; i < SEL_DEPTH; i++)
          if (sel_live[i] && sel_addr[i] == r.sender) is_sel = 1'b1;
        if (!is_sel) begin
          slot = -1;
          for (i = 0; i < SEL_DEPTH; i++)
            if (slot < 0 && !sel_live[i]) slot = i;
          if (slot >= 0) begin
            sel_live[slot] = 1'b1;
            sel_addr[slot] = r.sender;
          end else begin
            o.status = ST_SEL_FULL;
          end
        end
      end
      default: begin
        for (i = 0; i < SEL_DEPTH; i++)
          if (sel_live[i] && sel_addr[i] == r.sender) sel_live[i] = 1'b0;
      end
    endcase
    return o;
  endfunction

  function automatic req_t msg_item(input logic [31:0] orig, input logic [15:0] sn,
                                    input logic [31:0] src, input logic [7:0] ttl,
                                    input logic [7:0] hops);
    req_t r;
    r.cmd = CMD_MESSAGE;
    r.originator = orig;
    r.sequence_req = sn;
    r.sender = src;
    r.time_to_live = ttl;
    r.hop_count = hops;
    return r;
  endfunction

  function automatic req_t sel_item(input cmd_e cmd, input logic [31:0] addr);
    req_t r;
    r.cmd = cmd;
    r.originator = $urandom;
    r.sequence_req = 16'($urandom);
    r.sender = addr;
    r.time_to_live = 8'($urandom);
    r.hop_count = 8'($urandom);
    return r;
  endfunction

  function automatic req_t tick_item();
    return sel_item(CMD_TICK, $urandom);
  endfunction

  function automatic req_t random_item();
    req_t r;
    int   pick;
    r.cmd = CMD_MESSAGE;
    r.originator = $urandom;
    r.sequence_req = 16'($urandom);
    r.sender = $urandom;
    r.time_to_live = 8'($urandom);
    r.hop_count = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.cmd = cmd_e'($urandom_range(0, 3));
      if (r.cmd == CMD_SEL_ADD && $urandom_range(0, 1) == 0)
        r.sender = sel_pool[$urandom_range(0, 7)];
    end else if (pick < 60) begin
      r.originator = orig_pool[$urandom_range(0, 3)];
      r.sequence_req = seq_base + 16'($urandom_range(0, 5));
      if ($urandom_range(0, 99) < 85) r.sender = sel_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 3))
        0: r.time_to_live = 8'd1;
        1: r.time_to_live = 8'($urandom_range(0, 2));
        default: r.time_to_live = 8'($urandom);
      endcase
    end else if (pick < 78) begin
      r.cmd = CMD_TICK;
    end else if (pick < 92) begin
      r.cmd = CMD_SEL_ADD;
      r.sender = sel_pool[$urandom_range(0, 7)];
    end else begin
      r.cmd = CMD_SEL_REMOVE;
      r.sender = sel_pool[$urandom_range(0, 7)];
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("response %0d: %s mismatch, expected %0h, actual %0h",
               rsp_count, what, want, got);
  endfunction

  task automatic check_rsp(input rsp_t got);
    rsp_t want;
    rsp_count++;
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("response %0d: unexpected transaction, actual %p", rsp_count, got);
    end else begin
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        note_mismatch("status", 32'(want.status), 32'(got.status));
      if (got.forward !== want.forward)
        note_mismatch("forward", 32'(want.forward), 32'(got.forward));
      if (got.new_ttl !== want.new_ttl)
        note_mismatch("new_ttl", 32'(want.new_ttl), 32'(got.new_ttl));
      if (got.new_hop_count !== want.new_hop_count)
        note_mismatch("new_hop_count", 32'(want.new_hop_count), 32'(got.new_hop_count));
      if (got.dup_full !== want.dup_full)
        note_mismatch("dup_full", 32'(want.dup_full), 32'(got.dup_full));
    end
  endtask

  task automatic send_item(input req_t item);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.push_back(forward_decision(item));
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[APB_AW-1:2] == REG_HOLD_TICKS) hold_cfg = data[15:0];
  endtask

  task automatic verify_hold_reg();
    logic [31:0] data;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_HOLD;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (data[15:0] !== hold_cfg)
      note_mismatch("hold_ticks readback", 32'(hold_cfg), 32'(data[15:0]));
  endtask

  task automatic set_hold(input logic [15:0] value);
    settle();
    apb_write(ADDR_HOLD, {16'($urandom), value});
    verify_hold_reg();
  endtask

  task automatic run_ticks(input int n);
    int k;
    for (k = 0; k < n; k++) send_item(tick_item());
  endtask

  task automatic prune_selectors();
    int i;
    int j;
    bit known;
    for (i = 0; i < SEL_DEPTH; i++) begin
      known = 1'b0;
      for (j = 0; j < 8; j++)
        if (sel_pool[j] == sel_addr[i]) known = 1'b1;
      if (sel_live[i] && !known) send_item(sel_item(CMD_SEL_REMOVE, sel_addr[i]));
    end
  endtask

  task automatic test_directed();
    send_gap_max = 15;
    recv_gap_max = 15;
    verify_hold_reg();
    send_item(msg_item(32'h0, 16'h0, SEL_ZERO, 8'd0, 8'd0));
    send_item(sel_item(CMD_SEL_ADD, SEL_ALL_ONES));
    send_item(sel_item(CMD_SEL_ADD, SEL_ZERO));
    send_item(sel_item(CMD_SEL_ADD, SEL_ZERO));
    send_item(msg_item(32'hFFFF_FFFF, 16'hFFFF, SEL_ALL_ONES, 8'd255, 8'd255));
    send_item(msg_item(32'hFFFF_FFFF, 16'hFFFF, SEL_ALL_ONES, 8'd255, 8'd255));
    send_item(msg_item(32'h0, 16'h0, SEL_ZERO, 8'd0, 8'd0));
    send_item(msg_item(32'h1234_5678, 16'h0001, SEL_ZERO, 8'd1, 8'd7));
    send_item(msg_item(32'h1234_5678, 16'h0001, SEL_ZERO, 8'd9, 8'd7));
    send_item(msg_item(32'h1234_5678, 16'h0001, SEL_ZERO, 8'd9, 8'd7));
    send_item(tick_item());
    send_item(sel_item(CMD_SEL_REMOVE, SEL_ZERO));
    send_item(sel_item(CMD_SEL_REMOVE, 32'h5A5A_5A5A));
    send_item(msg_item(32'hA5A5_A5A5, 16'h0002, SEL_ZERO, 8'd3, 8'd0));
    send_item(msg_item(32'hA5A5_A5A5, 16'h0002, SEL_ALL_ONES, 8'd3, 8'd0));
    send_item(msg_item(32'h0F0F_0F0F, 16'h8000, SEL_ALL_ONES, 8'd2, 8'd254));
  endtask

  task automatic test_default_expiry();
    send_gap_max = 0;
    recv_gap_max = 0;
    run_ticks(20);
    send_item(msg_item(32'hFFFF_FFFF, 16'hFFFF, SEL_ALL_ONES, 8'd255, 8'd255));
    run_ticks(12);
  endtask

  task automatic test_dup_full();
    int k;
    send_gap_max = 3;
    recv_gap_max = 3;
    set_hold(16'd3);
    send_item(msg_item(32'hFFFF_FFFF, 16'hFFFF, SEL_ALL_ONES, 8'd255, 8'd255));
    for (k = 1; k < DUP_DEPTH; k++)
      send_item(msg_item(32'hD000_0000 + k, 16'(k), NON_SELECTOR, 8'd5, 8'd1));
    send_item(msg_item(32'hEEEE_0000, 16'd7, SEL_ALL_ONES, 8'd10, 8'd0));
    send_item(msg_item(32'hEEEE_0000, 16'd7, SEL_ALL_ONES, 8'd10, 8'd0));
    send_item(msg_item(32'hEEEE_0001, 16'd8, NON_SELECTOR, 8'd10, 8'd0));
    send_item(msg_item(32'hFFFF_FFFF, 16'hFFFF, SEL_ALL_ONES, 8'd255, 8'd255));
    run_ticks(3);
    send_item(msg_item(32'hEEEE_0000, 16'd7, SEL_ALL_ONES, 8'd10, 8'd0));
    run_ticks(3);
  endtask

  task automatic test_hold_extremes();
    req_t m;
    m = msg_item(32'h0C0C_0C0C, 16'h1234, SEL_ALL_ONES, 8'd64, 8'd3);
    send_gap_max = 0;
    recv_gap_max = 0;
    set_hold(16'hFFFF);
    send_item(m);
    run_ticks(30);
    send_item(m);
    run_ticks(1);
    send_gap_max = 15;
    recv_gap_max = 15;
    set_hold(16'd0);
    send_item(m);
    send_item(m);
    send_item(tick_item());
    send_item(m);
    send_item(tick_item());
    set_hold(16'd1);
    send_item(m);
    send_item(tick_item());
    send_item(m);
    send_item(tick_item());
    settle();
    apb_write(ADDR_SPARE, $urandom);
    verify_hold_reg();
  endtask

  task automatic test_selector_full();
    int k;
    send_gap_max = 2;
    recv_gap_max = 6;
    for (k = 0; k < SEL_DEPTH; k++) send_item(sel_item(CMD_SEL_ADD, 32'h1000_0000 + k));
    send_item(sel_item(CMD_SEL_ADD, SEL_ALL_ONES));
    send_item(msg_item($urandom, 16'($urandom), 32'h1000_000E, 8'd20, 8'd4));
    for (k = 0; k < SEL_DEPTH; k++)
      send_item(sel_item(CMD_SEL_REMOVE, 32'h1000_0000 + k));
  endtask

  task automatic test_backpressure();
    int k;
    send_gap_max = 0;
    recv_gap_max = 0;
    rsp_holdoff = LONG_HOLDOFF;
    for (k = 0; k < 40; k++) send_item(random_item());
  endtask

  task automatic test_random_traffic(input int n, input logic [15:0] hold,
                                     input int sgap, input int rgap);
    int k;
    set_hold(hold);
    send_gap_max = sgap;
    recv_gap_max = rgap;
    prune_selectors();
    for (k = 0; k < n; k++) send_item(random_item());
  endtask

  initial begin : rsp_side
    int gap;
    rsp_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rsp_holdoff > 0) gap = rsp_holdoff;
      else gap = $urandom_range(0, recv_gap_max);
      rsp_holdoff = 0;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      check_rsp(rsp);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_olsr_duplicate_filter_forwarder: done, errors");
    $finish;
  end

  initial begin : stimulus
    int i;
    rst_n <= 1'b0;
    req_valid <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_cfg = HOLD_DEFAULT;
    for (i = 0; i < DUP_DEPTH; i++) begin
      dup_live[i] = 1'b0;
      dup_orig[i] = '0;
      dup_sn[i] = '0;
      dup_fwd[i] = 1'b0;
      dup_left[i] = '0;
    end
    for (i = 0; i < SEL_DEPTH; i++) begin
      sel_live[i] = 1'b0;
      sel_addr[i] = '0;
    end
    for (i = 0; i < 8; i++) sel_pool[i] = $urandom;
    for (i = 0; i < 4; i++) orig_pool[i] = $urandom;
    seq_base = 16'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_default_expiry();
    test_dup_full();
    test_hold_extremes();
    test_selector_full();
    test_backpressure();
    test_random_traffic(350, 16'd2, 15, 15);
    test_random_traffic(350, 16'd12, 0, 0);
    test_random_traffic(300, 16'd40, 3, 15);
    test_random_traffic(200, 16'hFFFF, 15, 0);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_olsr_duplicate_filter_forwarder: done, clean");
    end else begin
      $display("tb_olsr_duplicate_filter_forwarder: done, errors");
    end
    $finish;
  end

endmodule
